/* rtl/assert_macros.svh */
// Assertion macros shared by the relay filter RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/fdr_pkg.sv */
// Types and constants of the flood relay duplicate filter.
// No dependencies; used by every module of the block but fdr_ram.
package fdr_pkg;

  localparam logic [7:0] MANUF_TYPE = 8'hFF;
  localparam logic [4:0] MIN_LEN    = 5'd2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_NODE_ID     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_COMPANY  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_COMPANY = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_LENGTH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMMAND_LENGTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLEEP_CODE      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEASURE_CODE    = 3'd6;

  localparam logic [2:0] VERDICT_SKIPPED      = 3'd0;
  localparam logic [2:0] VERDICT_OWN_ECHO     = 3'd1;
  localparam logic [2:0] VERDICT_SENSOR_DUP   = 3'd2;
  localparam logic [2:0] VERDICT_SENSOR_RELAY = 3'd3;
  localparam logic [2:0] VERDICT_SENSOR_HELD  = 3'd4;
  localparam logic [2:0] VERDICT_CMD_DUP      = 3'd5;
  localparam logic [2:0] VERDICT_CMD_NEW      = 3'd6;

  // Queue between classifier and cache engine; power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_ECHO,
    KIND_SENSOR,
    KIND_COMMAND
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] key;   // {byte_two, byte_three}
    logic [7:0]  code;  // byte_three, command code
  } item_t;

  typedef struct packed {
    logic [7:0]  own_node_id;
    logic [15:0] sensor_company;
    logic [15:0] command_company;
    logic [4:0]  sensor_length;
    logic [4:0]  command_length;
    logic [7:0]  sleep_code;
    logic [7:0]  measure_code;
  } cfg_t;

  typedef struct packed {
    logic       sleeping;
    logic       wake_sensors;
    logic       relay;
    logic [2:0] verdict;
  } result_t;

endpackage

/* rtl/fdr_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fdr_front.sv */
// Record classifier: report tracking and sensor/command decision.
// Depends on fdr_pkg.
module fdr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fdr_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              first_i,
  input  logic [7:0]        rtype_i,
  input  logic [4:0]        rlen_i,
  input  logic [15:0]       company_i,
  input  logic [7:0]        byte_two_i,
  input  logic [7:0]        byte_three_i,
  input  logic              q_full_i,
  output logic              push_o,
  output fdr_pkg::item_t    item_o
);

  logic matched_q, matched_d;
  logic prior, base, is_sens, is_cmd, accept;

  assign accept  = in_valid_i && !q_full_i;
  assign prior   = first_i ? 1'b0 : matched_q;
  assign base    = !prior && (rtype_i == fdr_pkg::MANUF_TYPE) && (rlen_i >= fdr_pkg::MIN_LEN);
  assign is_sens = base && (company_i == cfg_i.sensor_company)
                   && (rlen_i == cfg_i.sensor_length);
  assign is_cmd  = base && !is_sens && (company_i == cfg_i.command_company)
                   && (rlen_i == cfg_i.command_length);

  always_comb begin
    item_o.key  = {byte_two_i, byte_three_i};
    item_o.code = byte_three_i;
    if (is_sens) begin
      item_o.kind = (byte_two_i == cfg_i.own_node_id) ? fdr_pkg::KIND_ECHO
                                                      : fdr_pkg::KIND_SENSOR;
    end else if (is_cmd) begin
      item_o.kind = fdr_pkg::KIND_COMMAND;
    end else begin
      item_o.kind = fdr_pkg::KIND_SKIP;
    end
  end

  assign matched_d  = accept ? (prior || is_sens || is_cmd) : matched_q;
  assign in_ready_o = !q_full_i;
  assign push_o     = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= 1'b0;
    end else begin
      matched_q <= matched_d;
    end
  end

endmodule

/* rtl/fdr_queue.sv */
// Short FIFO of classified records between classifier and cache engine.
// Depends on fdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fdr_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output fdr_pkg::item_t item_o
);

  fdr_pkg::item_t             entries_q [fdr_pkg::QUEUE_DEPTH];
  logic [fdr_pkg::QPW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [fdr_pkg::QPW:0]      count_q, count_d;

  assign full_o  = (count_q == (fdr_pkg::QPW+1)'(fdr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + (fdr_pkg::QPW+1)'(1);
      2'b01:   count_d = count_q - (fdr_pkg::QPW+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  // Depth is a power of two, so pointers wrap by overflow.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + fdr_pkg::QPW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + fdr_pkg::QPW'(1);
      end
      count_q <= count_d;
    end
  end

  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && (count_q == '0), "queue popped while empty")
  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o && !pop_i, "queue pushed while full")

endmodule

/* rtl/fdr_back.sv */
// Cache engine: ring cache search/insert, mode update, output register.
// Depends on fdr_pkg, fdr_ram and assert_macros.svh.
`include "assert_macros.svh"

module fdr_back #(
  parameter int SENSOR_SEEN_DEPTH  = 16,
  parameter int COMMAND_SEEN_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fdr_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  fdr_pkg::item_t    item_i,
  output logic              item_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fdr_pkg::result_t  out_o
);

  localparam int SIW = (SENSOR_SEEN_DEPTH > 1) ? $clog2(SENSOR_SEEN_DEPTH) : 1;
  localparam int CIW = (COMMAND_SEEN_DEPTH > 1) ? $clog2(COMMAND_SEEN_DEPTH) : 1;
  localparam int MW  = (SIW > CIW) ? SIW : CIW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        sel_cmd_q, sel_cmd_d;
  logic [15:0] key_q, key_d;
  logic [7:0]  code_q, code_d;
  logic [MW-1:0] scan_idx_q, scan_idx_d, cmp_idx_q, cmp_idx_d;
  logic        issue_q, issue_d, cmp_v_q, cmp_v_d;
  logic        mode_q, mode_d;
  logic [SIW-1:0] s_wptr_q, s_wptr_d;
  logic [CIW-1:0] c_wptr_q, c_wptr_d;
  // Rings fill in order from slot 0: below the write pointer is valid,
  // and once the pointer has wrapped every slot is.
  logic        s_full_q, s_full_d;
  logic        c_full_q, c_full_d;
  fdr_pkg::result_t res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [15:0] s_rdata, c_rdata;
  logic        s_we, c_we, hit, done_miss, s_vld, c_vld;
  logic [MW-1:0] last_idx;

  fdr_ram #(.WIDTH(16), .DEPTH(SENSOR_SEEN_DEPTH)) u_sensor_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_wptr_q),
    .wdata_i (key_q),
    .raddr_i (scan_idx_q[SIW-1:0]),
    .rdata_o (s_rdata)
  );

  fdr_ram #(.WIDTH(16), .DEPTH(COMMAND_SEEN_DEPTH)) u_command_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_wptr_q),
    .wdata_i (key_q),
    .raddr_i (scan_idx_q[CIW-1:0]),
    .rdata_o (c_rdata)
  );

  // Compare stage sees the entry read in the previous cycle.
  assign last_idx  = sel_cmd_q ? MW'(COMMAND_SEEN_DEPTH - 1) : MW'(SENSOR_SEEN_DEPTH - 1);
  assign s_vld     = s_full_q || (cmp_idx_q < MW'(s_wptr_q));
  assign c_vld     = c_full_q || (cmp_idx_q < MW'(c_wptr_q));
  assign hit       = cmp_v_q && (sel_cmd_q ? (c_vld && (c_rdata == key_q))
                                           : (s_vld && (s_rdata == key_q)));
  assign done_miss = cmp_v_q && !hit && (cmp_idx_q == last_idx);
  assign s_we      = (state_q == S_SCAN) && done_miss && !sel_cmd_q;
  assign c_we      = (state_q == S_SCAN) && done_miss && sel_cmd_q;

  always_comb begin
    state_d     = state_q;
    sel_cmd_d   = sel_cmd_q;
    key_d       = key_q;
    code_d      = code_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    issue_d     = issue_q;
    cmp_v_d     = 1'b0;
    mode_d      = mode_q;
    s_wptr_d    = s_wptr_q;
    c_wptr_d    = c_wptr_q;
    s_full_d    = s_full_q;
    c_full_d    = c_full_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    item_pop_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o         = 1'b1;
          key_d              = item_i.key;
          code_d             = item_i.code;
          sel_cmd_d          = (item_i.kind == fdr_pkg::KIND_COMMAND);
          res_d.relay        = 1'b0;
          res_d.wake_sensors = 1'b0;
          res_d.sleeping     = mode_q;
          scan_idx_d         = '0;
          issue_d            = 1'b1;
          case (item_i.kind)
            fdr_pkg::KIND_ECHO: begin
              res_d.verdict = fdr_pkg::VERDICT_OWN_ECHO;
              state_d       = S_OUT;
            end
            fdr_pkg::KIND_SENSOR, fdr_pkg::KIND_COMMAND: begin
              state_d = S_SCAN;
            end
            default: begin
              res_d.verdict = fdr_pkg::VERDICT_SKIPPED;
              state_d       = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_idx_q;
          if (scan_idx_q == last_idx) begin
            issue_d = 1'b0;
          end else begin
            scan_idx_d = scan_idx_q + MW'(1);
          end
        end
        if (hit) begin
          res_d.verdict = sel_cmd_q ? fdr_pkg::VERDICT_CMD_DUP : fdr_pkg::VERDICT_SENSOR_DUP;
          state_d       = S_OUT;
        end else if (done_miss) begin
          state_d = S_OUT;
          if (sel_cmd_q) begin
            c_full_d = c_full_q || (c_wptr_q == CIW'(COMMAND_SEEN_DEPTH - 1));
            c_wptr_d = (c_wptr_q == CIW'(COMMAND_SEEN_DEPTH - 1)) ? '0
                                                                  : c_wptr_q + CIW'(1);
            res_d.verdict = fdr_pkg::VERDICT_CMD_NEW;
            res_d.relay   = 1'b1;
            // Sleep wins when both codes match.
            if (code_q == cfg_i.sleep_code) begin
              mode_d = 1'b1;
            end else if (code_q == cfg_i.measure_code) begin
              mode_d             = 1'b0;
              res_d.wake_sensors = 1'b1;
            end
          end else begin
            s_full_d = s_full_q || (s_wptr_q == SIW'(SENSOR_SEEN_DEPTH - 1));
            s_wptr_d = (s_wptr_q == SIW'(SENSOR_SEEN_DEPTH - 1)) ? '0
                                                                 : s_wptr_q + SIW'(1);
            res_d.verdict = mode_q ? fdr_pkg::VERDICT_SENSOR_HELD
                                   : fdr_pkg::VERDICT_SENSOR_RELAY;
            res_d.relay   = !mode_q;
          end
          res_d.sleeping = mode_d;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sel_cmd_q  <= sel_cmd_d;
    key_q      <= key_d;
    code_q     <= code_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      cmp_v_q     <= 1'b0;
      mode_q      <= 1'b0;
      s_wptr_q    <= '0;
      c_wptr_q    <= '0;
      s_full_q    <= 1'b0;
      c_full_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      cmp_v_q     <= cmp_v_d;
      mode_q      <= mode_d;
      s_wptr_q    <= s_wptr_d;
      c_wptr_q    <= c_wptr_d;
      s_full_q    <= s_full_d;
      c_full_q    <= c_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_PROP(a_mode_only_on_new_cmd, clk_i, rst_ni, !$stable(mode_q) |-> $past((state_q == S_SCAN) && done_miss && sel_cmd_q), "mode changed outside a new command")
  `ASSERT_PROP(a_out_from_result, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_OUT), "output loaded outside the result state")

endmodule

/* rtl/flood_duplicate_filter_relay_core.sv */
// Flood relay duplicate filter: classifier, queue and cache engine.
// A cached record gets one RAM read per entry, with a full search on a miss;
//   the engine takes the next record once the last result is in the output register.
// Reset (rst_ni, async low): cache fill flags, ring pointers, mode and the
//   report flag clear at once; no clearing pass. Config takes its reset values.
module flood_duplicate_filter_relay_core #(
  parameter int SENSOR_SEEN_DEPTH  = 16,  // 1..256
  parameter int COMMAND_SEEN_DEPTH = 16   // 1..256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [fdr_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [fdr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Record stream in
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] record_type, [12:8] record_len, [28:13] maker_id,
  // [36:29] byte_two, [44:37] byte_three, [47:45] zero
  input  logic [47:0]                    s_axis_tdata_i,
  // [0] first_in_report
  input  logic                           s_axis_tuser_i,
  // Verdict stream out
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [2:0] verdict, [3] relay, [4] wake_sensors, [5] sleeping, [7:6] zero
  output logic [7:0]                     m_axis_tdata_o
);

  fdr_pkg::cfg_t    cfg_q;
  fdr_pkg::item_t   front_item, q_item;
  fdr_pkg::result_t result;
  logic             push, q_full, q_valid, q_pop;

  // Config registers; writes outside the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_node_id     <= 8'd0;
      cfg_q.sensor_company  <= 16'd0;
      cfg_q.command_company <= 16'd0;
      cfg_q.sensor_length   <= 5'd12;
      cfg_q.command_length  <= 5'd4;
      cfg_q.sleep_code      <= 8'd1;
      cfg_q.measure_code    <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fdr_pkg::CFG_OWN_NODE_ID:     cfg_q.own_node_id     <= cfg_wdata_i[7:0];
        fdr_pkg::CFG_SENSOR_COMPANY:  cfg_q.sensor_company  <= cfg_wdata_i;
        fdr_pkg::CFG_COMMAND_COMPANY: cfg_q.command_company <= cfg_wdata_i;
        fdr_pkg::CFG_SENSOR_LENGTH:   cfg_q.sensor_length   <= cfg_wdata_i[4:0];
        fdr_pkg::CFG_COMMAND_LENGTH:  cfg_q.command_length  <= cfg_wdata_i[4:0];
        fdr_pkg::CFG_SLEEP_CODE:      cfg_q.sleep_code      <= cfg_wdata_i[7:0];
        fdr_pkg::CFG_MEASURE_CODE:    cfg_q.measure_code    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Front: decides the record class and the report match per transaction.
  fdr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .first_i      (s_axis_tuser_i),
    .rtype_i      (s_axis_tdata_i[7:0]),
    .rlen_i       (s_axis_tdata_i[12:8]),
    .company_i    (s_axis_tdata_i[28:13]),
    .byte_two_i   (s_axis_tdata_i[36:29]),
    .byte_three_i (s_axis_tdata_i[44:37]),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Decouples intake from the cache search so records keep arriving while it has room.
  fdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  // Back: ring caches in RAM, searched one entry per cycle, then mode update.
  fdr_back #(
    .SENSOR_SEEN_DEPTH  (SENSOR_SEEN_DEPTH),
    .COMMAND_SEEN_DEPTH (COMMAND_SEEN_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (result)
  );

  assign m_axis_tdata_o = {2'b00, result.sleeping, result.wake_sensors,
                           result.relay, result.verdict};

endmodule
